/* design/glr_pkg.sv */
// Shared types and constants for the gradient line rasterizer.
package glr_pkg;

	localparam int IMAGE_W          = 512;
	localparam int COLOUR_FRAC_BITS = 10;
	localparam int COORD_W          = 9;
	localparam int CHAN_W           = 8;
	localparam int ACC_W            = CHAN_W + COLOUR_FRAC_BITS;
	localparam int STEP_W           = ACC_W + 1;
	localparam int ERR_W            = 12;
	localparam int ADDR_W           = 20;
	localparam int CNT_W            = $clog2(ACC_W);
	localparam int NUM_CHAN         = 3;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	typedef struct packed {
		logic               command;
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic [CHAN_W-1:0]  start_red;
		logic [CHAN_W-1:0]  start_green;
		logic [CHAN_W-1:0]  start_blue;
		logic [CHAN_W-1:0]  end_red;
		logic [CHAN_W-1:0]  end_green;
		logic [CHAN_W-1:0]  end_blue;
	} cmd_t;

	typedef struct packed {
		logic               pixel_valid;
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [ADDR_W-1:0]  byte_address;
		logic [CHAN_W-1:0]  pixel_red;
		logic [CHAN_W-1:0]  pixel_green;
		logic [CHAN_W-1:0]  pixel_blue;
		logic               last_pixel;
	} pix_t;

	// Status of the shared divider as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* design/gradient_line_rasterizer.sv */
// Top level of the gradient line rasterizer: command sequencer, line state and output register.
//
// The block draws one line at a time. Each beat on the cmd channel is either a start
// command, which loads two endpoints and two colours, or a step command, which advances
// the line by one pixel. Every accepted command beat yields exactly one beat on the pix
// channel in the following cycle, held in an output register.
// A start beat emits the first pixel immediately, then the block spends three passes of
// its shared restoring divider (one per colour channel) computing the colour steps. Each
// pass runs the launch state and then waits while the divider works out the ACC_W (18)
// quotient bits, and cmd_stall stays high until the last pass ends for a line of nonzero
// length. A zero-length line skips the divider and draws a single pixel marked last.
// A step beat needs no divider pass, so steps stream at one per clock while the receiver keeps
// up. A step with no active line returns a beat whose fields are all zero.
// The pix side is registered: when pix_stall is high the pending beat holds, and cmd_stall
// rises so that no further command is taken until that beat leaves.
// Reset (arst_n low) clears the sequencer, the line state and the output register; the
// block then holds no active line.
module gradient_line_rasterizer
	import glr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic pix_valid,
	input  logic pix_stall,
	output pix_t pix
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_LAUNCH,
		ST_DIV_WAIT
	} state_t;

	state_t state_q;

	// Line state.
	logic                     active_q;
	logic [COORD_W-1:0]       major_q;
	logic [COORD_W-1:0]       minor_q;
	logic [COORD_W-1:0]       steps_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [ERR_W-1:0]  sinc_q;
	logic signed [ERR_W-1:0]  dinc_q;
	logic [2:0]               oct_q;
	logic [ACC_W-1:0]         acc_q   [NUM_CHAN];
	logic [STEP_W-1:0]        cstep_q [NUM_CHAN];

	// Divider operands held during the colour step passes.
	logic [ACC_W-1:0]         mag_q   [NUM_CHAN];
	logic                     neg_q   [NUM_CHAN];
	logic [1:0]               ch_q;

	logic                     pix_valid_q;
	pix_t                     pix_q;

	div_stat_t                div_stat;
	logic [ACC_W-1:0]         div_quo;
	logic                     div_start;

	logic                     accept;

	// Builds an output beat from the current axis positions and colours.
	function automatic pix_t emit(input logic [COORD_W-1:0] maj, input logic [COORD_W-1:0] mnr,
			input logic swap, input logic [ACC_W-1:0] r, input logic [ACC_W-1:0] g,
			input logic [ACC_W-1:0] b, input logic last);
		pix_t               p;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		x = swap ? mnr : maj;
		y = swap ? maj : mnr;
		p.pixel_valid  = 1'b1;
		p.pixel_x      = x;
		p.pixel_y      = y;
		p.byte_address = ADDR_W'((ADDR_W'(x) + ADDR_W'(y) * ADDR_W'(IMAGE_W)) << 2);
		p.pixel_red    = r[ACC_W-1 -: CHAN_W];
		p.pixel_green  = g[ACC_W-1 -: CHAN_W];
		p.pixel_blue   = b[ACC_W-1 -: CHAN_W];
		p.last_pixel   = last;
		return p;
	endfunction

	// Start command setup: octant, major axis, error terms and colour differences.
	logic               st_xneg, st_yneg, st_swap;
	logic [COORD_W-1:0] st_adx, st_ady, st_maj, st_mnr, st_major, st_minor;
	logic signed [ERR_W-1:0] st_err, st_sinc, st_dinc;
	logic [CHAN_W-1:0]  st_s [NUM_CHAN];
	logic [CHAN_W-1:0]  st_e [NUM_CHAN];
	logic [ACC_W-1:0]   st_acc [NUM_CHAN];
	logic [ACC_W-1:0]   st_mag [NUM_CHAN];
	logic               st_neg [NUM_CHAN];
	pix_t               st_pix;

	always_comb begin
		st_xneg  = cmd.end_x < cmd.start_x;
		st_yneg  = cmd.end_y < cmd.start_y;
		st_adx   = st_xneg ? (cmd.start_x - cmd.end_x) : (cmd.end_x - cmd.start_x);
		st_ady   = st_yneg ? (cmd.start_y - cmd.end_y) : (cmd.end_y - cmd.start_y);
		// Ties between the two deltas keep x as the major axis.
		st_swap  = st_ady > st_adx;
		st_maj   = st_swap ? st_ady : st_adx;
		st_mnr   = st_swap ? st_adx : st_ady;
		st_major = st_swap ? cmd.start_y : cmd.start_x;
		st_minor = st_swap ? cmd.start_x : cmd.start_y;
		st_sinc  = ERR_W'({st_mnr, 1'b0});
		st_dinc  = st_sinc - ERR_W'({st_maj, 1'b0});
		st_err   = st_sinc - ERR_W'(st_maj);
		st_s[0]  = cmd.start_red;
		st_s[1]  = cmd.start_green;
		st_s[2]  = cmd.start_blue;
		st_e[0]  = cmd.end_red;
		st_e[1]  = cmd.end_green;
		st_e[2]  = cmd.end_blue;
		for (int c = 0; c < NUM_CHAN; c++) begin
			st_neg[c] = st_e[c] < st_s[c];
			st_acc[c] = {st_s[c], {COLOUR_FRAC_BITS{1'b0}}};
			st_mag[c] = {(st_neg[c] ? (st_s[c] - st_e[c]) : (st_e[c] - st_s[c])),
				{COLOUR_FRAC_BITS{1'b0}}};
		end
		st_pix = emit(st_major, st_minor, st_swap, st_acc[0], st_acc[1], st_acc[2],
			st_maj == '0);
	end

	// Step command: one midpoint decision and one colour step per channel.
	logic               sp_swap, sp_majneg, sp_minneg, sp_diag, sp_go;
	logic [COORD_W-1:0] sp_major, sp_minor, sp_steps;
	logic signed [ERR_W-1:0] sp_err;
	logic [ACC_W-1:0]   sp_acc [NUM_CHAN];
	pix_t               sp_pix;

	always_comb begin
		sp_go     = active_q && (steps_q != '0);
		sp_swap   = oct_q[0];
		sp_majneg = sp_swap ? oct_q[2] : oct_q[1];
		sp_minneg = sp_swap ? oct_q[1] : oct_q[2];
		sp_diag   = err_q > 0;
		sp_err    = err_q + (sp_diag ? dinc_q : sinc_q);
		sp_major  = sp_majneg ? (major_q - 1'b1) : (major_q + 1'b1);
		sp_minor  = !sp_diag ? minor_q : (sp_minneg ? (minor_q - 1'b1) : (minor_q + 1'b1));
		sp_steps  = steps_q - 1'b1;
		for (int c = 0; c < NUM_CHAN; c++) begin
			sp_acc[c] = acc_q[c] + cstep_q[c][ACC_W-1:0];
		end
		if (sp_go) begin
			sp_pix = emit(sp_major, sp_minor, sp_swap, sp_acc[0], sp_acc[1], sp_acc[2],
				sp_steps == '0);
		end else begin
			sp_pix = '0;
		end
	end

	assign cmd_stall = (state_q != ST_IDLE) || (pix_valid_q && pix_stall);
	assign accept    = cmd_valid && !cmd_stall;
	assign div_start = (state_q == ST_DIV_LAUNCH);
	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

	glr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_q[ch_q]),
		.divisor  (steps_q),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= 1'b0;
			major_q     <= '0;
			minor_q     <= '0;
			steps_q     <= '0;
			err_q       <= '0;
			sinc_q      <= '0;
			dinc_q      <= '0;
			oct_q       <= '0;
			ch_q        <= '0;
			pix_valid_q <= 1'b0;
			pix_q       <= '0;
			for (int c = 0; c < NUM_CHAN; c++) begin
				acc_q[c]   <= '0;
				cstep_q[c] <= '0;
				mag_q[c]   <= '0;
				neg_q[c]   <= 1'b0;
			end
		end else begin
			if (accept) begin
				pix_valid_q <= 1'b1;
			end else if (!pix_stall) begin
				pix_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && cmd.command == CMD_START) begin
						pix_q    <= st_pix;
						active_q <= st_maj != '0;
						major_q  <= st_major;
						minor_q  <= st_minor;
						steps_q  <= st_maj;
						err_q    <= st_err;
						sinc_q   <= st_sinc;
						dinc_q   <= st_dinc;
						oct_q    <= {st_yneg, st_xneg, st_swap};
						ch_q     <= '0;
						for (int c = 0; c < NUM_CHAN; c++) begin
							acc_q[c]   <= st_acc[c];
							cstep_q[c] <= '0;
							mag_q[c]   <= st_mag[c];
							neg_q[c]   <= st_neg[c];
						end
						if (st_maj != '0) begin
							state_q <= ST_DIV_LAUNCH;
						end
					end else if (accept) begin
						pix_q <= sp_pix;
						if (sp_go) begin
							major_q  <= sp_major;
							minor_q  <= sp_minor;
							err_q    <= sp_err;
							steps_q  <= sp_steps;
							active_q <= sp_steps != '0;
							for (int c = 0; c < NUM_CHAN; c++) begin
								acc_q[c] <= sp_acc[c];
							end
						end else begin
							active_q <= 1'b0;
						end
					end
				end
				ST_DIV_LAUNCH: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_stat.done) begin
						cstep_q[ch_q] <= neg_q[ch_q] ? (STEP_W'(0) - {1'b0, div_quo})
							: {1'b0, div_quo};
						if (ch_q == 2'(NUM_CHAN - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= ST_DIV_LAUNCH;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// An active line always has at least one pixel left.
	a_active_has_steps: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (steps_q != '0))
		else $error("active line with no steps remaining");

	// A start of nonzero length holds off the next command while the colour steps are built.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.command == CMD_START &&
			(cmd.start_x != cmd.end_x || cmd.start_y != cmd.end_y)) |=> cmd_stall)
		else $error("command taken during colour step division");

	// The divider reports a quotient only while the sequencer waits for one.
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV_WAIT))
		else $error("divider finished outside its wait state");

	// Divider is idle whenever commands can be taken.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_stat.busy)
		else $error("divider busy while sequencer idle");

endmodule

/* design/glr_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module glr_div
	import glr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [ACC_W-1:0]   dividend,
	input  logic [COORD_W-1:0] divisor,
	output div_stat_t          stat,
	output logic [ACC_W-1:0]   quotient
);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [COORD_W-1:0] rem_q;
	logic [COORD_W-1:0] dvs_q;
	logic [ACC_W-1:0]   quo_q;

	logic [COORD_W:0]   trial;
	logic               fits;
	logic [COORD_W-1:0] rem_n;

	always_comb begin
		trial = {rem_q, quo_q[ACC_W-1]};
		fits  = (trial >= {1'b0, dvs_q});
		rem_n = fits ? COORD_W'(trial - {1'b0, dvs_q}) : trial[COORD_W-1:0];
	end

	assign quotient  = {quo_q[ACC_W-2:0], fits};
	assign stat.busy = busy_q;
	assign stat.done = busy_q && (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(ACC_W - 1);
			rem_q  <= '0;
			dvs_q  <= divisor;
			quo_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[ACC_W-2:0], fits};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule
